### src/chd_pkg.sv
// Shared types, byte codes and helpers for the chunked body decoder.
`default_nettype none

package chd_pkg;

  // Special bytes of the size line and chunk trailer
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // Sticky error codes reported with every result word
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX  = 2'd1;
  localparam logic [1:0] ERR_NO_CRLF  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CHUNKED_MODE   = 1'b0;
  localparam logic CFG_CONTENT_LENGTH = 1'b1;

  // Chunked decoder phases
  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_SIZE_LF = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_DATA_CR = 7'b0001000,
    PH_DATA_LF = 7'b0010000,
    PH_END_CR  = 7'b0100000,
    PH_END_LF  = 7'b1000000
  } phase_t;

  // One result word
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       body_done;
    logic [1:0] error_code;
  } result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, 4'(b - 8'h30)};
      [8'h41:8'h46]: r = {1'b1, 4'(b - 8'h37)};
      [8'h61:8'h66]: r = {1'b1, 4'(b - 8'h57)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/chd_step.sv
// Per-byte decode state and next-state logic for the chunked body decoder.
`default_nettype none

module chd_step
  import chd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic        action,
  input  wire logic [7:0]  data_byte,
  input  wire logic        chunked_mode,
  input  wire logic [31:0] content_length,
  output result_t          res
);

  localparam int TOP_NIB = SIZE_BITS - 4;

  phase_t                 phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   chunk_rem_r, chunk_rem_nxt;
  logic [3:0]             digits_r, digits_nxt;
  logic                   skip_ext_r, skip_ext_nxt;
  logic [31:0]            len_cnt_r, len_cnt_nxt;
  logic                   done_r, done_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   pass;
  logic [4:0]             hex;
  logic [SIZE_BITS-1:0]   rem_dec;
  logic [31:0]            len_inc;

  assign hex     = hex_decode(data_byte);
  assign rem_dec = chunk_rem_r - SIZE_BITS'(1);
  assign len_inc = len_cnt_r + 32'd1;

  // Decode one byte
  always_comb begin
    phase_nxt     = phase_r;
    chunk_rem_nxt = chunk_rem_r;
    digits_nxt    = digits_r;
    skip_ext_nxt  = skip_ext_r;
    len_cnt_nxt   = len_cnt_r;
    done_nxt      = done_r;
    err_nxt       = err_r;
    pass          = 1'b0;
    if (action) begin
      phase_nxt     = PH_SIZE;
      chunk_rem_nxt = '0;
      digits_nxt    = 4'd0;
      skip_ext_nxt  = 1'b0;
      len_cnt_nxt   = 32'd0;
      done_nxt      = 1'b0;
      err_nxt       = ERR_NONE;
    end else if (!done_r && err_r == ERR_NONE) begin
      if (chunked_mode) begin
        case (phase_r)
          PH_SIZE: begin
            if (data_byte == BYTE_CR) begin
              if (digits_r == 4'd0) err_nxt = ERR_BAD_HEX;
              else phase_nxt = PH_SIZE_LF;
            end else if (!skip_ext_r) begin
              if (!hex[4]) begin
                if (digits_r == 4'd0) err_nxt = ERR_BAD_HEX;
                else skip_ext_nxt = 1'b1;
              end else if (chunk_rem_r[SIZE_BITS-1:TOP_NIB] != 4'd0) begin
                err_nxt = ERR_OVERFLOW;
              end else begin
                chunk_rem_nxt = {chunk_rem_r[TOP_NIB-1:0], hex[3:0]};
                if (digits_r != 4'd15) digits_nxt = digits_r + 4'd1;
              end
            end
          end
          PH_SIZE_LF: begin
            if (data_byte == BYTE_LF) begin
              digits_nxt   = 4'd0;
              skip_ext_nxt = 1'b0;
              phase_nxt    = (chunk_rem_r == '0) ? PH_END_CR : PH_DATA;
            end else if (data_byte != BYTE_CR) begin
              skip_ext_nxt = 1'b1;
              phase_nxt    = PH_SIZE;
            end
          end
          PH_DATA: begin
            chunk_rem_nxt = rem_dec;
            if (rem_dec == '0) phase_nxt = PH_DATA_CR;
            pass = 1'b1;
          end
          PH_DATA_CR: begin
            if (data_byte == BYTE_CR) phase_nxt = PH_DATA_LF;
            else err_nxt = ERR_NO_CRLF;
          end
          PH_DATA_LF: begin
            if (data_byte == BYTE_LF) phase_nxt = PH_SIZE;
            else err_nxt = ERR_NO_CRLF;
          end
          PH_END_CR: begin
            if (data_byte == BYTE_CR) phase_nxt = PH_END_LF;
            else err_nxt = ERR_NO_CRLF;
          end
          PH_END_LF: begin
            if (data_byte == BYTE_LF) done_nxt = 1'b1;
            else err_nxt = ERR_NO_CRLF;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end else begin
        // Fixed length: stop when the count is reached
        if (len_cnt_r >= content_length) begin
          done_nxt = 1'b1;
        end else begin
          len_cnt_nxt = len_inc;
          if (len_inc == content_length) done_nxt = 1'b1;
          pass = 1'b1;
        end
      end
    end
  end

  // Build the result word
  always_comb begin
    res.out_valid  = pass;
    res.out_byte   = pass ? data_byte : 8'd0;
    res.body_done  = done_nxt;
    res.error_code = err_nxt;
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      chunk_rem_r <= '0;
      digits_r    <= 4'd0;
      skip_ext_r  <= 1'b0;
      len_cnt_r   <= 32'd0;
      done_r      <= 1'b0;
      err_r       <= ERR_NONE;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      chunk_rem_r <= chunk_rem_nxt;
      digits_r    <= digits_nxt;
      skip_ext_r  <= skip_ext_nxt;
      len_cnt_r   <= len_cnt_nxt;
      done_r      <= done_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### src/http_chunked_body_decoder_unit.sv
// Top level of the HTTP message body decoder: config registers, decoder and result buffer.
`default_nettype none

// Decodes an HTTP/1.1 message body one byte per input word, in chunked or fixed
// length mode, and returns exactly one result word per input word. A word is
// decoded in the cycle it is accepted; its result is registered into the result
// buffer and reaches the output once older results are taken. The decoder takes
// one word every cycle while in_stall is low. The buffer holds two words, so input
// keeps flowing while one result waits on out_stall; in_stall rises only when both
// buffer slots are held. Errors and completion stay set until a word with in_action
// high restarts the decoder. Write the configuration only while the block is idle.
module http_chunked_body_decoder_unit
  import chd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic             out_body_done,
  output logic [1:0]       out_error_code
);

  logic        chunked_mode_r;
  logic [31:0] content_length_r;
  logic        in_acc;
  logic        out_acc;
  result_t     step_res;
  result_t     buf_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  result_t     head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_mode_r   <= 1'b0;
      content_length_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNKED_MODE:   chunked_mode_r   <= cfg_wdata[0];
        CFG_CONTENT_LENGTH: content_length_r <= cfg_wdata;
        default:            chunked_mode_r   <= chunked_mode_r;
      endcase
    end
  end

  assign in_stall = (count_r == 2'd2);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  chd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (in_acc),
    .action         (in_action),
    .data_byte      (in_in_byte),
    .chunked_mode   (chunked_mode_r),
    .content_length (content_length_r),
    .res            (step_res)
  );

  // Result buffer: push on accept, pop on take
  always_ff @(posedge clk) begin
    if (in_acc) buf_r[wr_ptr_r] <= step_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (in_acc) wr_ptr_r <= ~wr_ptr_r;
      if (out_acc) rd_ptr_r <= ~rd_ptr_r;
      case ({in_acc, out_acc})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Drive the head word
  assign head           = buf_r[rd_ptr_r];
  assign out_valid      = (count_r != 2'd0);
  assign out_out_valid  = head.out_valid;
  assign out_out_byte   = head.out_byte;
  assign out_body_done  = head.body_done;
  assign out_error_code = head.error_code;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=> out_valid)
    else $error("accepted word produced no result");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_valid) |-> (out_error_code == ERR_NONE))
    else $error("payload byte passed with an error set");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_valid) |-> (out_out_byte == 8'd0))
    else $error("non-payload result carries a byte");

endmodule

`default_nettype wire

### tb/http_chunked_body_decoder_unit_tb.sv
// Self-checking testbench for the HTTP chunked/fixed-length body decoder unit.
`timescale 1ns / 100ps

module http_chunked_body_decoder_unit_tb;
  import chd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 90;
  localparam int PHASE_WORDS = 185;

  // One input word: restart flag and received byte
  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } in_word_t;

  // Body decoder predictor and store of predicted result words
  class body_scoreboard;
    bit         chunked;
    bit [31:0]  content_len;
    phase_t     ph;
    bit [31:0]  remaining;
    bit [3:0]   digits;
    bit         skip_ext;
    bit [31:0]  len_count;
    bit         done;
    bit [1:0]   err;
    result_t    predicted_q[$];
    int         fails;

    function new();
      chunked = 1'b0;
      content_len = 32'd0;
      fails = 0;
      restart_message();
    endfunction

    function void restart_message();
      ph = PH_SIZE;
      remaining = 32'd0;
      digits = 4'd0;
      skip_ext = 1'b0;
      len_count = 32'd0;
      done = 1'b0;
      err = ERR_NONE;
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction

    function int hex_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      return -1;
    endfunction

    // Advance the chunked parser by one byte; return 1 for a payload byte
    function bit chunk_byte(logic [7:0] b);
      int hv;
      case (ph)
        PH_SIZE: begin
          if (b == BYTE_CR) begin
            if (digits == 4'd0) err = ERR_BAD_HEX;
            else ph = PH_SIZE_LF;
            return 1'b0;
          end
          if (skip_ext) return 1'b0;
          hv = hex_of(b);
          if (hv < 0) begin
            if (digits == 4'd0) err = ERR_BAD_HEX;
            else skip_ext = 1'b1;
            return 1'b0;
          end
          if (remaining[31:28] != 4'd0) begin
            err = ERR_OVERFLOW;
            return 1'b0;
          end
          remaining = {remaining[27:0], 4'(hv)};
          if (digits != 4'd15) digits = digits + 4'd1;
          return 1'b0;
        end
        PH_SIZE_LF: begin
          if (b == BYTE_LF) begin
            digits = 4'd0;
            skip_ext = 1'b0;
            ph = (remaining == 32'd0) ? PH_END_CR : PH_DATA;
          end else if (b != BYTE_CR) begin
            skip_ext = 1'b1;
            ph = PH_SIZE;
          end
          return 1'b0;
        end
        PH_DATA: begin
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) ph = PH_DATA_CR;
          return 1'b1;
        end
        PH_DATA_CR: begin
          if (b == BYTE_CR) ph = PH_DATA_LF;
          else err = ERR_NO_CRLF;
          return 1'b0;
        end
        PH_END_CR: begin
          if (b == BYTE_CR) ph = PH_END_LF;
          else err = ERR_NO_CRLF;
          return 1'b0;
        end
        PH_DATA_LF: begin
          if (b == BYTE_LF) ph = PH_SIZE;
          else err = ERR_NO_CRLF;
          return 1'b0;
        end
        PH_END_LF: begin
          if (b == BYTE_LF) done = 1'b1;
          else err = ERR_NO_CRLF;
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Count one byte in fixed length mode; return 1 for a payload byte
    function bit length_byte();
      if (len_count >= content_len) begin
        done = 1'b1;
        return 1'b0;
      end
      len_count = len_count + 32'd1;
      if (len_count == content_len) done = 1'b1;
      return 1'b1;
    endfunction

    // Predict the result word of an accepted input word
    function void note_word(logic action, logic [7:0] b);
      result_t r;
      bit pass;
      r = '0;
      pass = 1'b0;
      if (action) begin
        restart_message();
        predicted_q.push_back(r);
        return;
      end
      if (!done && err == ERR_NONE) begin
        if (chunked) pass = chunk_byte(b);
        else pass = length_byte();
      end
      r.out_valid = pass;
      r.out_byte = pass ? b : 8'h00;
      r.body_done = done;
      r.error_code = err;
      predicted_q.push_back(r);
    endfunction

    task report(string what);
      fails++;
      if (fails <= 100) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Compare an accepted result word with the oldest prediction
    task check_result(result_t got);
      result_t want;
      if (predicted_q.size() == 0) begin
        report($sformatf("result word with nothing pending: %p", got));
        return;
      end
      want = predicted_q.pop_front();
      if (got.out_valid !== want.out_valid)
        report($sformatf("out_valid %b, predicted %b", got.out_valid, want.out_valid));
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %0h, predicted %0h", got.out_byte, want.out_byte));
      if (got.body_done !== want.body_done)
        report($sformatf("body_done %b, predicted %b", got.body_done, want.body_done));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, predicted %0d", got.error_code, want.error_code));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [7:0]  in_in_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_body_done;
  logic [1:0]  out_error_code;

  body_scoreboard sb = new();
  in_word_t       msg_q[$];
  int             words_in = 0;
  bit             idling = 1'b1;

  http_chunked_body_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_in_byte     (in_in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_valid  (out_out_valid),
    .out_out_byte   (out_out_byte),
    .out_body_done  (out_body_done),
    .out_error_code (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Word building helpers
  function automatic void put(logic act, logic [7:0] b);
    in_word_t w;
    w.action = act;
    w.data = b;
    msg_q.push_back(w);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(1'b0, s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Emit a chunk size in hex, sometimes with leading zeros, a few times many of them
  function automatic void put_size(logic [31:0] v);
    int n;
    int zeros;
    n = 8;
    while (n > 1 && v[4*n-1 -: 4] == 4'd0) n--;
    case ($urandom_range(0, 11))
      0, 1:    zeros = $urandom_range(1, 3);
      2:       zeros = $urandom_range(15, 17);
      default: zeros = 0;
    endcase
    repeat (zeros) put(1'b0, "0");
    for (int i = n - 1; i >= 0; i--) put(1'b0, hex_char(v[4*i +: 4]));
  endfunction

  // Emit extension text after the size digits, with a lone CR now and then
  function automatic void put_extension();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       put(1'b0, ";");
      1:       put(1'b0, " ");
      2:       put(1'b0, "z");
      default: put(1'b0, 8'hFF);
    endcase
    repeat ($urandom_range(0, 5)) begin
      c = 8'($urandom);
      if (c == BYTE_CR) c = "x";
      put(1'b0, c);
    end
    case ($urandom_range(0, 5))
      0: begin put(1'b0, BYTE_CR); put(1'b0, "q"); end
      1: put(1'b0, BYTE_CR);
      default: ;
    endcase
  endfunction

  function automatic void put_crlf();
    put(1'b0, BYTE_CR);
    put(1'b0, BYTE_LF);
  endfunction

  // Build a chunked message with random content; damage some of them
  function automatic void build_chunked();
    int start;
    int sz;
    int idx;
    start = msg_q.size();
    if ($urandom_range(0, 7) != 0) put(1'b1, 8'($urandom));
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 19) == 0) begin
        // huge chunk, cut short by the next message
        put_size($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom));
        put_crlf();
        repeat ($urandom_range(1, 12)) put(1'b0, 8'($urandom));
        return;
      end
      sz = $urandom_range(1, 12);
      put_size(sz);
      if ($urandom_range(0, 2) == 0) put_extension();
      put_crlf();
      repeat (sz) put(1'b0, 8'($urandom));
      put_crlf();
    end
    put_size(32'd0);
    if ($urandom_range(0, 3) == 0) put_extension();
    put_crlf();
    put_crlf();
    case ($urandom_range(0, 7))
      0: begin
        idx = $urandom_range(start, msg_q.size() - 1);
        msg_q[idx].data = 8'($urandom);
      end
      1: begin
        idx = $urandom_range(start + 1, msg_q.size() - 1);
        while (msg_q.size() > idx) void'(msg_q.pop_back());
      end
      2: begin
        // size line with more significant digits than fit
        put(1'b1, 8'($urandom));
        repeat ($urandom_range(9, 11)) put(1'b0, hex_char(4'($urandom_range(1, 15))));
        put_crlf();
      end
      3: begin
        put(1'b1, 8'($urandom));
        case ($urandom_range(0, 3))
          0:       put(1'b0, BYTE_CR);
          1:       put(1'b0, BYTE_LF);
          2:       put(1'b0, "g");
          default: put(1'b0, 8'($urandom));
        endcase
      end
      default: ;
    endcase
  endfunction

  // Build a fixed length message around the configured length
  function automatic void build_length(logic [31:0] len);
    int n;
    if ($urandom_range(0, 7) != 0) put(1'b1, 8'($urandom));
    if (len == 32'd0) n = $urandom_range(1, 3);
    else if (len <= 32'd40) n = $urandom_range(int'(len) - 1, int'(len) + 3);
    else n = $urandom_range(5, 40);
    repeat (n) put($urandom_range(0, 39) == 0, 8'($urandom));
  endfunction

  function automatic void put_noise();
    repeat ($urandom_range(1, 10)) put($urandom_range(0, 15) == 0, 8'($urandom));
  endfunction

  // Write both registers while the block is idle
  task automatic configure(bit mode, logic [31:0] len);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHUNKED_MODE;
    cfg_wdata <= {31'd0, mode};
    @(posedge clk);
    cfg_index <= CFG_CONTENT_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.chunked = mode;
    sb.content_len = len;
  endtask

  // Offer queued words one at a time, with random gaps while idling is set
  task automatic drive_words();
    in_word_t w;
    while (msg_q.size() != 0) begin
      w = msg_q.pop_front();
      in_valid <= 1'b1;
      in_action <= w.action;
      in_in_byte <= w.data;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_word(w.action, w.data);
      words_in++;
      if (idling && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Main stimulus
  initial begin : stimulus
    bit          mode;
    logic [31:0] len;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CHUNKED_MODE;
    cfg_wdata <= 32'd0;
    in_valid <= 1'b0;
    in_action <= 1'b0;
    in_in_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Chunked: extension with lone CR, full body, bytes after done, bad size, bad trailer
    configure(1'b1, 32'd0);
    put(1'b1, 8'hFF);
    put_text("1\015x\015\n");
    put(1'b0, 8'hFF);
    put_text("\015\n0\015\n\015\n");
    put(1'b0, 8'h00);
    put(1'b1, 8'h00);
    put_text("G");
    put(1'b1, 8'h00);
    put(1'b0, BYTE_CR);
    put(1'b1, 8'h00);
    put_text("1\015\nAx");
    drive_words();
    wait_drained();

    // Fixed length: count reached, then a partial body carried across mode switches
    configure(1'b0, 32'd2);
    put(1'b1, 8'h00);
    put(1'b0, 8'h00);
    put(1'b0, 8'hFF);
    put(1'b0, 8'h41);
    put(1'b1, 8'h00);
    put(1'b0, 8'h7F);
    drive_words();
    wait_drained();
    configure(1'b1, 32'd2);
    put_text("2\015\n");
    drive_words();
    wait_drained();
    configure(1'b0, 32'd2);
    put(1'b0, 8'h55);
    drive_words();
    wait_drained();

    // Random phases; the last one runs without idling
    for (int p = 0; p < 10; p++) begin
      idling = (p != 9) && ($urandom_range(0, 3) != 0);
      case (p)
        0: begin mode = 1'b0; len = 32'd0; end
        1: begin mode = 1'b0; len = 32'hFFFF_FFFF; end
        2: begin mode = 1'b1; len = 32'd7; end
        default: begin
          mode = $urandom_range(0, 2) != 0;
          case ($urandom_range(0, 3))
            0:       len = 32'd0;
            1:       len = 32'hFFFF_FFFF;
            2:       len = 32'($urandom_range(1, 40));
            default: len = 32'($urandom);
          endcase
        end
      endcase
      configure(mode, len);
      while (msg_q.size() < PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 8) begin
          if (mode) build_chunked();
          else build_length(len);
        end else begin
          put_noise();
        end
      end
      drive_words();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.fails == 0) $display("http_chunked_body_decoder_unit_tb passed");
    else $display("http_chunked_body_decoder_unit_tb failed");
    $finish;
  end

  // Result side: random stall bursts and one long hold-off to back up the block
  initial begin : result_sink
    bit squeezed;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!squeezed && words_in >= 400) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_out_valid, out_out_byte, out_body_done, out_error_code});
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("http_chunked_body_decoder_unit_tb failed");
    $finish;
  end

endmodule

### http_chunked_body_decoder_unit.f
src/chd_pkg.sv
src/chd_step.sv
src/http_chunked_body_decoder_unit.sv
tb/http_chunked_body_decoder_unit_tb.sv
